/* rtl/core/rxz_pkg.sv */
// package: widths, latencies and face codes for the xz ray box slab test
`timescale 1ns / 1ps
package rxz_pkg;
	localparam int Q_W           = 32;
	localparam int MARGIN_W      = 16;
	localparam int HALF_W        = 31;
	localparam int FACE_W        = 3;
	localparam int MAG_W         = 34;
	localparam int QBITS         = 31;
	localparam int DIV_LAT       = QBITS + 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;
	localparam logic [ADDR_W-1:0] ADDR_BOX_MARGIN = 3'd0;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd6554;
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;
	localparam logic [FACE_W-1:0] FACE_NONE = 3'd0;
	localparam logic [FACE_W-1:0] FACE_PX   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NX   = 3'd2;
	localparam logic [FACE_W-1:0] FACE_PZ   = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NZ   = 3'd4;

	typedef struct packed {
		logic signed [Q_W-1:0] ox;
		logic signed [Q_W-1:0] oy;
		logic signed [Q_W-1:0] oz;
		logic signed [Q_W-1:0] dx;
		logic signed [Q_W-1:0] dy;
		logic signed [Q_W-1:0] dz;
		logic                  zero_x;
		logic                  zero_z;
		logic                  in_x;
		logic                  in_z;
	} side_t;
endpackage

/* rtl/core/rxz_if.sv */
// interfaces: ray input channel and result output channel
`timescale 1ns / 1ps
interface rxz_ray_if;
	logic valid;
	logic ready;
	logic signed [rxz_pkg::Q_W-1:0] ray_origin_x;
	logic signed [rxz_pkg::Q_W-1:0] ray_origin_y;
	logic signed [rxz_pkg::Q_W-1:0] ray_origin_z;
	logic signed [rxz_pkg::Q_W-1:0] ray_dir_x;
	logic signed [rxz_pkg::Q_W-1:0] ray_dir_y;
	logic signed [rxz_pkg::Q_W-1:0] ray_dir_z;
	logic signed [rxz_pkg::Q_W-1:0] box_center_x;
	logic signed [rxz_pkg::Q_W-1:0] box_center_z;
	logic [rxz_pkg::HALF_W-1:0] box_half_x;
	logic [rxz_pkg::HALF_W-1:0] box_half_z;
	modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
		ray_dir_y, ray_dir_z, box_center_x, box_center_z, box_half_x, box_half_z,
		input ready);
	modport sink (input valid, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
		ray_dir_y, ray_dir_z, box_center_x, box_center_z, box_half_x, box_half_z,
		output ready);
endinterface

interface rxz_res_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [rxz_pkg::Q_W-1:0] entry_time;
	logic signed [rxz_pkg::Q_W-1:0] contact_x;
	logic signed [rxz_pkg::Q_W-1:0] contact_y;
	logic signed [rxz_pkg::Q_W-1:0] contact_z;
	logic [rxz_pkg::FACE_W-1:0] face_normal;
	modport source (output valid, hit, entry_time, contact_x, contact_y, contact_z,
		face_normal, input ready);
	modport sink (input valid, hit, entry_time, contact_x, contact_y, contact_z,
		face_normal, output ready);
endinterface

/* rtl/core/rxz_div.sv */
// pipelined restoring divider, one quotient bit per stage, signed saturated result
`timescale 1ns / 1ps
module rxz_div #(
	parameter int FRAC_BITS = rxz_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [rxz_pkg::MAG_W-1:0]         num_mag,
	input  logic [rxz_pkg::Q_W-1:0]           den_mag,
	input  logic                              neg,
	output logic signed [rxz_pkg::Q_W-1:0]    quo
);
	localparam int QB = rxz_pkg::QBITS;
	localparam int NW = rxz_pkg::MAG_W + FRAC_BITS;

	logic [NW-1:0] nsh;
	logic [63:0]   top64;
	logic          ovf_c;

	logic [31:0]   p_s   [0:QB];
	logic [QB-1:0] n_s   [0:QB];
	logic [31:0]   d_s   [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];

	assign nsh   = {num_mag, {FRAC_BITS{1'b0}}};
	assign top64 = 64'(nsh >> QB);
	assign ovf_c = top64 >= {32'd0, den_mag};

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0]   <= top64[31:0];
			n_s[0]   <= nsh[QB-1:0];
			d_s[0]   <= den_mag;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf_c;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;
		assign t    = {p_s[k], n_s[k][QB-1-k]};
		assign diff = t - {1'b0, d_s[k]};
		assign ge   = !diff[32];
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k+1]   <= ge ? diff[31:0] : t[31:0];
				n_s[k+1]   <= n_s[k];
				d_s[k+1]   <= d_s[k];
				q_s[k+1]   <= {q_s[k][QB-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic signed [rxz_pkg::Q_W-1:0] mag_c;
	logic signed [rxz_pkg::Q_W-1:0] res_c;

	always_comb begin
		mag_c = {1'b0, q_s[QB]};
		if (ovf_s[QB])
			res_c = neg_s[QB] ? rxz_pkg::Q_MIN : rxz_pkg::Q_MAX;
		else
			res_c = neg_s[QB] ? -mag_c : mag_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= res_c;
		end
	end
endmodule

/* rtl/core/rxz_contact.sv */
// contact coordinate: origin plus direction times entry time, floor shift, saturated
`timescale 1ns / 1ps
module rxz_contact #(
	parameter int FRAC_BITS = rxz_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           keep,
	input  logic signed [rxz_pkg::Q_W-1:0] o,
	input  logic signed [rxz_pkg::Q_W-1:0] d,
	input  logic signed [rxz_pkg::Q_W-1:0] t,
	output logic signed [rxz_pkg::Q_W-1:0] c
);
	logic signed [63:0]             prod_s1;
	logic signed [rxz_pkg::Q_W-1:0] o_s1;
	logic                           keep_s1;
	logic signed [63:0]             sh_c;
	logic signed [64:0]             sum_c;
	logic signed [rxz_pkg::Q_W-1:0] sat_c;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(d) * 64'(t);
			o_s1    <= o;
			keep_s1 <= keep;
		end
	end

	always_comb begin
		sh_c  = prod_s1 >>> FRAC_BITS;
		sum_c = 65'(o_s1) + 65'(sh_c);
		if (sum_c > 65'(rxz_pkg::Q_MAX))
			sat_c = rxz_pkg::Q_MAX;
		else if (sum_c < 65'(rxz_pkg::Q_MIN))
			sat_c = rxz_pkg::Q_MIN;
		else
			sat_c = sum_c[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c <= keep_s1 ? sat_c : '0;
		end
	end
endmodule

/* rtl/core/xz_ray_box_slab_intersect_core.sv */
// top level: xz ray versus padded box slab test pipeline with apb margin register
//
// channel   | dir | handshake     | word
// ray_in    | in  | valid / ready | ray origin, direction, box centre and half extents
// res_out   | out | valid / ready | hit, entry time, contact point, face code
// apb       | in  | psel/penable  | box_margin at address 0
//
// one word per cycle while the output word is taken; most of the pipe depth lies in the bit-per-stage dividers
// arst_n clears valid bits and resets box_margin to 0.1
// the whole pipe holds when the output word is not taken; nothing is lost or repeated
`timescale 1ns / 1ps
module xz_ray_box_slab_intersect_core #(
	parameter int FRAC_BITS = rxz_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rxz_ray_if.sink                      ray_in,
	rxz_res_if.source                    res_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rxz_pkg::ADDR_W-1:0]   paddr,
	input  logic [rxz_pkg::DATA_W-1:0]   pwdata,
	output logic [rxz_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	localparam int DL  = rxz_pkg::DIV_LAT;
	localparam int NST = 3 + DL + 4;

	logic [rxz_pkg::MARGIN_W-1:0] margin_q;
	logic                         en;
	logic [NST-1:0]               v_q;

	assign pready = 1'b1;
	assign prdata = (paddr == rxz_pkg::ADDR_BOX_MARGIN) ? 32'(margin_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= rxz_pkg::MARGIN_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == rxz_pkg::ADDR_BOX_MARGIN) begin
			margin_q <= pwdata[rxz_pkg::MARGIN_W-1:0];
		end
	end

	assign en           = !v_q[NST-1] || res_out.ready;
	assign ray_in.ready = en;
	assign res_out.valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], ray_in.valid};
		end
	end

	// s1: padded bounds
	logic signed [35:0] lox_s1, hix_s1, loz_s1, hiz_s1;
	rxz_pkg::side_t     sd_s1, sd_s2, sd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			lox_s1 <= 36'(ray_in.box_center_x) - 36'(ray_in.box_half_x) - 36'(margin_q);
			hix_s1 <= 36'(ray_in.box_center_x) + 36'(ray_in.box_half_x) + 36'(margin_q);
			loz_s1 <= 36'(ray_in.box_center_z) - 36'(ray_in.box_half_z) - 36'(margin_q);
			hiz_s1 <= 36'(ray_in.box_center_z) + 36'(ray_in.box_half_z) + 36'(margin_q);
			sd_s1.ox <= ray_in.ray_origin_x;
			sd_s1.oy <= ray_in.ray_origin_y;
			sd_s1.oz <= ray_in.ray_origin_z;
			sd_s1.dx <= ray_in.ray_dir_x;
			sd_s1.dy <= ray_in.ray_dir_y;
			sd_s1.dz <= ray_in.ray_dir_z;
			sd_s1.zero_x <= 1'b0;
			sd_s1.zero_z <= 1'b0;
			sd_s1.in_x <= 1'b0;
			sd_s1.in_z <= 1'b0;
		end
	end

	// s2: numerators, inside test, direction magnitude
	logic signed [35:0] nlx_s2, nhx_s2, nlz_s2, nhz_s2;
	logic [31:0]        dmx_s2, dmz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nlx_s2 <= lox_s1 - 36'(sd_s1.ox);
			nhx_s2 <= hix_s1 - 36'(sd_s1.ox);
			nlz_s2 <= loz_s1 - 36'(sd_s1.oz);
			nhz_s2 <= hiz_s1 - 36'(sd_s1.oz);
			dmx_s2 <= sd_s1.dx[31] ? (~sd_s1.dx + 32'd1) : sd_s1.dx;
			dmz_s2 <= sd_s1.dz[31] ? (~sd_s1.dz + 32'd1) : sd_s1.dz;
			sd_s2.ox <= sd_s1.ox;
			sd_s2.oy <= sd_s1.oy;
			sd_s2.oz <= sd_s1.oz;
			sd_s2.dx <= sd_s1.dx;
			sd_s2.dy <= sd_s1.dy;
			sd_s2.dz <= sd_s1.dz;
			sd_s2.zero_x <= sd_s1.dx == '0;
			sd_s2.zero_z <= sd_s1.dz == '0;
			sd_s2.in_x <= 36'(sd_s1.ox) >= lox_s1 && 36'(sd_s1.ox) <= hix_s1;
			sd_s2.in_z <= 36'(sd_s1.oz) >= loz_s1 && 36'(sd_s1.oz) <= hiz_s1;
		end
	end

	// s3: magnitudes and quotient signs
	logic [rxz_pkg::MAG_W-1:0] mlx_s3, mhx_s3, mlz_s3, mhz_s3;
	logic [31:0]               dmx_s3, dmz_s3;
	logic                      glx_s3, ghx_s3, glz_s3, ghz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mlx_s3 <= rxz_pkg::MAG_W'(nlx_s2[35] ? -nlx_s2 : nlx_s2);
			mhx_s3 <= rxz_pkg::MAG_W'(nhx_s2[35] ? -nhx_s2 : nhx_s2);
			mlz_s3 <= rxz_pkg::MAG_W'(nlz_s2[35] ? -nlz_s2 : nlz_s2);
			mhz_s3 <= rxz_pkg::MAG_W'(nhz_s2[35] ? -nhz_s2 : nhz_s2);
			glx_s3 <= nlx_s2[35] ^ sd_s2.dx[31];
			ghx_s3 <= nhx_s2[35] ^ sd_s2.dx[31];
			glz_s3 <= nlz_s2[35] ^ sd_s2.dz[31];
			ghz_s3 <= nhz_s2[35] ^ sd_s2.dz[31];
			dmx_s3 <= dmx_s2;
			dmz_s3 <= dmz_s2;
			sd_s3 <= sd_s2;
		end
	end

	logic signed [31:0] qlx, qhx, qlz, qhz;

	rxz_div #(.FRAC_BITS(FRAC_BITS)) u_div_lx (
		.clk(clk), .en(en), .num_mag(mlx_s3), .den_mag(dmx_s3), .neg(glx_s3), .quo(qlx));
	rxz_div #(.FRAC_BITS(FRAC_BITS)) u_div_hx (
		.clk(clk), .en(en), .num_mag(mhx_s3), .den_mag(dmx_s3), .neg(ghx_s3), .quo(qhx));
	rxz_div #(.FRAC_BITS(FRAC_BITS)) u_div_lz (
		.clk(clk), .en(en), .num_mag(mlz_s3), .den_mag(dmz_s3), .neg(glz_s3), .quo(qlz));
	rxz_div #(.FRAC_BITS(FRAC_BITS)) u_div_hz (
		.clk(clk), .en(en), .num_mag(mhz_s3), .den_mag(dmz_s3), .neg(ghz_s3), .quo(qhz));

	rxz_pkg::side_t sd_dq [0:DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_dq[0] <= sd_s3;
			for (int i = 1; i < DL; i++) begin
				sd_dq[i] <= sd_dq[i-1];
			end
		end
	end

	// s4: ordered slab times
	logic signed [31:0] tnx_s4, tfx_s4, tnz_s4, tfz_s4;
	logic               miss_s4;
	rxz_pkg::side_t     sd_s4, sd_s5;
	rxz_pkg::side_t     sdd;

	assign sdd = sd_dq[DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sdd.zero_x) begin
				tnx_s4 <= rxz_pkg::Q_MIN;
				tfx_s4 <= rxz_pkg::Q_MAX;
			end else begin
				tnx_s4 <= (qlx > qhx) ? qhx : qlx;
				tfx_s4 <= (qlx > qhx) ? qlx : qhx;
			end
			if (sdd.zero_z) begin
				tnz_s4 <= rxz_pkg::Q_MIN;
				tfz_s4 <= rxz_pkg::Q_MAX;
			end else begin
				tnz_s4 <= (qlz > qhz) ? qhz : qlz;
				tfz_s4 <= (qlz > qhz) ? qlz : qhz;
			end
			miss_s4 <= (sdd.zero_x && !sdd.in_x) || (sdd.zero_z && !sdd.in_z);
			sd_s4 <= sdd;
		end
	end

	// s5: overlap, entry time, face
	logic                        hit_c, hit_s5, hit_s6, hit_s7;
	logic signed [31:0]          tnear_c, tfar_c, tn_s5, tn_s6, tn_s7;
	logic [rxz_pkg::FACE_W-1:0]  face_c, face_s5, face_s6, face_s7;

	always_comb begin
		tnear_c = (tnx_s4 > tnz_s4) ? tnx_s4 : tnz_s4;
		tfar_c  = (tfx_s4 < tfz_s4) ? tfx_s4 : tfz_s4;
		hit_c   = !miss_s4 && !(tnx_s4 > tfz_s4) && !(tnz_s4 > tfx_s4) && !tfar_c[31];
		if (tnx_s4 > tnz_s4)
			face_c = sd_s4.dx[31] ? rxz_pkg::FACE_PX : rxz_pkg::FACE_NX;
		else if (tnx_s4 < tnz_s4)
			face_c = sd_s4.dz[31] ? rxz_pkg::FACE_PZ : rxz_pkg::FACE_NZ;
		else
			face_c = rxz_pkg::FACE_NONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5  <= hit_c;
			tn_s5   <= hit_c ? tnear_c : '0;
			face_s5 <= hit_c ? face_c : rxz_pkg::FACE_NONE;
			sd_s5   <= sd_s4;
			hit_s6  <= hit_s5;
			tn_s6   <= tn_s5;
			face_s6 <= face_s5;
			hit_s7  <= hit_s6;
			tn_s7   <= tn_s6;
			face_s7 <= face_s6;
		end
	end

	rxz_contact #(.FRAC_BITS(FRAC_BITS)) u_cx (
		.clk(clk), .en(en), .keep(hit_s5), .o(sd_s5.ox), .d(sd_s5.dx), .t(tn_s5),
		.c(res_out.contact_x));
	rxz_contact #(.FRAC_BITS(FRAC_BITS)) u_cy (
		.clk(clk), .en(en), .keep(hit_s5), .o(sd_s5.oy), .d(sd_s5.dy), .t(tn_s5),
		.c(res_out.contact_y));
	rxz_contact #(.FRAC_BITS(FRAC_BITS)) u_cz (
		.clk(clk), .en(en), .keep(hit_s5), .o(sd_s5.oz), .d(sd_s5.dz), .t(tn_s5),
		.c(res_out.contact_z));

	assign res_out.hit         = hit_s7;
	assign res_out.entry_time  = tn_s7;
	assign res_out.face_normal = face_s7;
endmodule

/* test/rxz_slab_checker.sv */
// checker: predicts each slab test result and compares it with the block's output word
`timescale 1ns / 1ps
module rxz_slab_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	rxz_ray_if                         ray,
	rxz_res_if                         res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [rxz_pkg::ADDR_W-1:0] paddr,
	input  logic [rxz_pkg::DATA_W-1:0] pwdata,
	output int                         fails,
	output int                         pending
);
	import rxz_pkg::*;
	localparam int FB = FRAC_BITS_DEF;

	typedef struct {
		bit                    hit;
		bit signed [Q_W-1:0]   entry;
		bit signed [Q_W-1:0]   px;
		bit signed [Q_W-1:0]   py;
		bit signed [Q_W-1:0]   pz;
		bit [FACE_W-1:0]       face;
	} hit_word_t;

	hit_word_t expected_hits[$];
	bit [MARGIN_W-1:0] margin;

	function automatic longint clamp_q(longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	function automatic longint slab_time(longint num, longint den);
		bit neg;
		longint unsigned un, ud, q;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = (un << FB) / ud;
		if (neg) return q >= 64'h8000_0000 ? longint'(Q_MIN) : -longint'(q);
		return q > 64'h7fff_ffff ? longint'(Q_MAX) : longint'(q);
	endfunction

	function automatic bit slab_span(longint o, longint d, longint c, longint h,
			output longint tn, output longint tf);
		longint lo, hi, a, b;
		lo = c - h - longint'(margin);
		hi = c + h + longint'(margin);
		if (d == 0) begin
			tn = longint'(Q_MIN);
			tf = longint'(Q_MAX);
			return o >= lo && o <= hi;
		end
		a = slab_time(lo - o, d);
		b = slab_time(hi - o, d);
		tn = a < b ? a : b;
		tf = a < b ? b : a;
		return 1'b1;
	endfunction

	function automatic longint contact_at(longint o, longint d, longint t);
		longint p;
		p = d * t;
		return clamp_q(o + (p >>> FB));
	endfunction

	function automatic hit_word_t predict_hit(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz, longint cx, longint cz,
			longint hx, longint hz);
		hit_word_t w;
		longint tnx, tfx, tnz, tfz, tn, tf;
		w = '{default: 0};
		if (!slab_span(ox, dx, cx, hx, tnx, tfx)) return w;
		if (!slab_span(oz, dz, cz, hz, tnz, tfz)) return w;
		if (tnx > tfz || tnz > tfx) return w;
		tn = tnx > tnz ? tnx : tnz;
		tf = tfx < tfz ? tfx : tfz;
		if (tf < 0) return w;
		if (tnx > tnz) w.face = dx < 0 ? FACE_PX : FACE_NX;
		else if (tnx < tnz) w.face = dz < 0 ? FACE_PZ : FACE_NZ;
		else w.face = FACE_NONE;
		w.hit = 1'b1;
		w.entry = tn[31:0];
		w.px = Q_W'(contact_at(ox, dx, tn));
		w.py = Q_W'(contact_at(oy, dy, tn));
		w.pz = Q_W'(contact_at(oz, dz, tn));
		return w;
	endfunction

	assign pending = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		hit_word_t e;
		if (!arst_n) begin
			margin <= MARGIN_RESET;
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_BOX_MARGIN)
				margin <= pwdata[MARGIN_W-1:0];
			if (ray.valid && ray.ready)
				expected_hits.push_back(predict_hit(ray.ray_origin_x, ray.ray_origin_y,
					ray.ray_origin_z, ray.ray_dir_x, ray.ray_dir_y, ray.ray_dir_z,
					ray.box_center_x, ray.box_center_z,
					longint'({1'b0, ray.box_half_x}), longint'({1'b0, ray.box_half_z})));
			if (res.valid && res.ready) begin
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result word hit=%0b", $time, res.hit);
					fails++;
				end else begin
					e = expected_hits.pop_front();
					if (res.hit !== e.hit || res.entry_time !== e.entry
							|| res.contact_x !== e.px || res.contact_y !== e.py
							|| res.contact_z !== e.pz || res.face_normal !== e.face) begin
						$display("%0t: mismatch expected hit=%0b t=%0d p=(%0d,%0d,%0d) face=%0d",
							$time, e.hit, e.entry, e.px, e.py, e.pz, e.face);
						$display("%0t:          actual   hit=%0b t=%0d p=(%0d,%0d,%0d) face=%0d",
							$time, res.hit, res.entry_time, res.contact_x, res.contact_y,
							res.contact_z, res.face_normal);
						fails++;
					end
				end
			end
		end
	end
endmodule

/* test/tb_xz_ray_box_slab_intersect_core.sv */
// testbench top: ray stimulus, margin register phases, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_xz_ray_box_slab_intersect_core;
	import rxz_pkg::*;
	localparam int LAT = 3 + DIV_LAT + 4;
	localparam int STUCK_LIMIT = 20000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic [HALF_W-1:0] ONE_H = 31'h0001_0000;

	typedef struct {
		logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cz;
		logic [HALF_W-1:0]  hx, hz;
	} ray_word_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	int fails, pending;
	int stuck = 0;

	rxz_ray_if ray_in ();
	rxz_res_if res_out ();

	xz_ray_box_slab_intersect_core i_dut (
		.clk(clk), .arst_n(arst_n), .ray_in(ray_in.sink), .res_out(res_out.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rxz_slab_checker i_checker (
		.clk(clk), .arst_n(arst_n), .ray(ray_in), .res(res_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] any_q();
		case ($urandom_range(0, 5))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] near_q(logic signed [31:0] base, int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic ray_word_t make_ray();
		ray_word_t r;
		if ($urandom_range(0, 9) < 2) begin
			r = '{any_q(), any_q(), any_q(), any_q(), any_q(), any_q(), any_q(), any_q(),
				HALF_W'($urandom), HALF_W'($urandom)};
			return r;
		end
		r.cx = $signed($urandom_range(0, 64 * 65536)) - 32 * 65536;
		r.cz = $signed($urandom_range(0, 64 * 65536)) - 32 * 65536;
		r.hx = HALF_W'($urandom_range(0, 4 * 65536));
		r.hz = HALF_W'($urandom_range(0, 4 * 65536));
		r.ox = near_q(r.cx, 10 * 65536);
		r.oz = near_q(r.cz, 10 * 65536);
		r.oy = any_q();
		r.dx = (r.cx - r.ox) + $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
		r.dz = (r.cz - r.oz) + $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
		r.dy = near_q(0, 3 * 65536);
		case ($urandom_range(0, 9))
			0: r.dx = 0;
			1: r.dz = 0;
			2: r.dx = $signed($urandom_range(0, 64)) - 32;
			3: r.dy = any_q();
			4: begin r.dx = -r.dx; r.dz = -r.dz; end
			default: ;
		endcase
		return r;
	endfunction

	task automatic apb_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_ray(ray_word_t r);
		ray_in.valid <= 1;
		ray_in.ray_origin_x <= r.ox; ray_in.ray_origin_y <= r.oy;
		ray_in.ray_origin_z <= r.oz; ray_in.ray_dir_x <= r.dx;
		ray_in.ray_dir_y <= r.dy; ray_in.ray_dir_z <= r.dz;
		ray_in.box_center_x <= r.cx; ray_in.box_center_z <= r.cz;
		ray_in.box_half_x <= r.hx; ray_in.box_half_z <= r.hz;
		forever begin
			@(negedge clk);
			if (ray_in.ready) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic send_burst_run(int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && left > 0; k++, left--)
				send_ray(make_ray());
			if ($urandom_range(0, 3) != 0) begin
				ray_in.valid <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		ray_in.valid <= 0;
	endtask

	task automatic send_directed();
		ray_word_t r;
		logic signed [31:0] ext[4];
		ext = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1};
		// each face, tie, behind, zero direction inside and outside
		send_ray('{-5 * ONE, 0, 0, ONE, ONE, 0, 0, 0, ONE_H, ONE_H});
		send_ray('{5 * ONE, 0, 0, -ONE, -ONE, 0, 0, 0, ONE_H, ONE_H});
		send_ray('{0, 0, -5 * ONE, 0, 0, ONE, 0, 0, ONE_H, ONE_H});
		send_ray('{0, 0, 5 * ONE, 0, 0, -ONE, 0, 0, ONE_H, ONE_H});
		send_ray('{-5 * ONE, 0, -5 * ONE, ONE, ONE, ONE, 0, 0, ONE_H, ONE_H});
		send_ray('{5 * ONE, 0, 0, ONE, 0, 0, 0, 0, ONE_H, ONE_H});
		send_ray('{0, 0, 9 * ONE, ONE, 0, 0, 0, 0, ONE_H, ONE_H});
		send_ray('{0, 0, 0, 0, ONE, 0, 0, 0, 31'd0, 31'd0});
		send_ray('{0, 0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd0});
		send_ray('{0, ONE, 0, 1, 32'sh7fff_ffff, -1, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff});
		foreach (ext[i]) begin
			foreach (ext[j]) begin
				r = '{ext[i], ext[j], ext[j], ext[j], ext[i], ext[i], ext[j], ext[i],
					31'h7fff_ffff, {31{ext[j][0]}}};
				send_ray(r);
			end
		end
		ray_in.valid <= 0;
	endtask

	initial begin
		ray_in.valid <= 0;
		ray_in.ray_origin_x <= 0; ray_in.ray_origin_y <= 0; ray_in.ray_origin_z <= 0;
		ray_in.ray_dir_x <= 0; ray_in.ray_dir_y <= 0; ray_in.ray_dir_z <= 0;
		ray_in.box_center_x <= 0; ray_in.box_center_z <= 0;
		ray_in.box_half_x <= 0; ray_in.box_half_z <= 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
		arst_n <= 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_directed();
		send_burst_run(300);
		drain();
		apb_write(ADDR_BOX_MARGIN, 0);
		send_directed();
		send_burst_run(300);
		drain();
		apb_write(ADDR_BOX_MARGIN, 32'hffff_ffff);
		send_directed();
		send_burst_run(300);
		drain();
		apb_write(ADDR_BOX_MARGIN, $urandom);
		send_burst_run(300);
		drain();
		if (fails == 0) begin
			$display("** xz_ray_box_slab_intersect_core: PASSED **");
		end else begin
			$display("** xz_ray_box_slab_intersect_core: FAILED **");
		end
		$finish;
	end

	initial begin
		int mode, span;
		res_out.ready <= 0;
		@(posedge arst_n);
		// long hold while the sender keeps offering words, so the pipe fills up
		wait (pending > 0);
		res_out.ready <= 0;
		repeat (300) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				case (mode)
					0: res_out.ready <= 1;
					1: res_out.ready <= $urandom_range(0, 1);
					2: res_out.ready <= $urandom_range(0, 3) == 0;
					default: res_out.ready <= $urandom_range(0, 7) != 0;
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((ray_in.valid && ray_in.ready) || (res_out.valid && res_out.ready))
			stuck <= 0;
		else if (arst_n)
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("** xz_ray_box_slab_intersect_core: FAILED **");
			$finish;
		end
	end
endmodule

/* files.f */
rtl/core/rxz_pkg.sv
rtl/core/rxz_if.sv
rtl/core/rxz_div.sv
rtl/core/rxz_contact.sv
rtl/core/xz_ray_box_slab_intersect_core.sv
test/rxz_slab_checker.sv
test/tb_xz_ray_box_slab_intersect_core.sv
